// ===== design/oets_pkg.sv =====
// Shared types and constants for the odd-even transposition sorter.
`timescale 1ns / 1ps
`default_nettype none
package oets_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int DATA_WIDTH       = 32;

    // One input item
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sorted_value;
        logic                         end_of_set;
        logic                         dropped;
    } result_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic sort_step;
        logic emit_step;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic phase_last;
        logic emit_last;
    } status_t;

endpackage
`default_nettype wire

// ===== design/oets_ctrl.sv =====
// Controller state machine for the odd-even transposition sorter.
`timescale 1ns / 1ps
`default_nettype none
module oets_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire logic             item_last,
    output logic                  item_ready,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output oets_pkg::cmd_t        cmd,
    input  wire oets_pkg::status_t status
);

    oets_pkg::state_t state_reg;
    oets_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oets_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        item_ready    = 1'b0;
        result_valid  = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            oets_pkg::ST_LOAD:
            begin
                item_ready = 1'b1;
                cmd.load   = item_valid;
                if (item_valid && item_last)
                begin
                    state_next = oets_pkg::ST_SORT;
                end
            end
            oets_pkg::ST_SORT:
            begin
                cmd.sort_step = 1'b1;
                if (status.phase_last)
                begin
                    state_next = oets_pkg::ST_EMIT;
                end
            end
            oets_pkg::ST_EMIT:
            begin
                result_valid  = 1'b1;
                cmd.emit_step = result_ready;
                if (result_ready && status.emit_last)
                begin
                    state_next = oets_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = oets_pkg::ST_LOAD;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/oets_datapath.sv =====
// Element row, compare-swap cells, counters and result path of the sorter.
`timescale 1ns / 1ps
`default_nettype none
module oets_datapath #(
    parameter int MAX_ELEMENTS = oets_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire oets_pkg::cmd_t      cmd,
    input  wire oets_pkg::in_item_t  item,
    output oets_pkg::status_t        status,
    output oets_pkg::result_t        result
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int PW = $clog2(MAX_ELEMENTS);
    localparam int DW = oets_pkg::DATA_WIDTH;

    logic signed [DW-1:0] store_reg  [MAX_ELEMENTS];
    logic signed [DW-1:0] store_next [MAX_ELEMENTS];
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [PW-1:0]        phase_reg;
    logic [PW-1:0]        phase_next;
    logic                 overflow_reg;
    logic                 overflow_next;
    logic                 full;

    assign full              = (count_reg == CW'(MAX_ELEMENTS));
    assign status.phase_last = (CW'(phase_reg) == count_reg - CW'(1));
    assign status.emit_last  = (count_reg == CW'(1));

    // Result comes from the head of the row
    assign result.sorted_value = store_reg[0];
    assign result.end_of_set   = status.emit_last;
    assign result.dropped      = overflow_reg;

    // Load, compare-swap and shift-out paths of the element row
    always_comb
    begin
        logic odd_cell;
        logic in_set;
        odd_cell = 1'b0;
        in_set   = 1'b0;
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            store_next[i] = store_reg[i];
        end
        if (cmd.load && !full)
        begin
            store_next[count_reg[PW-1:0]] = item.value;
        end
        if (cmd.sort_step)
        begin
            for (int i = 0; i < MAX_ELEMENTS - 1; i++)
            begin
                odd_cell = ((i % 2) == 1);
                in_set   = (CW'(i + 1) < count_reg);
                if ((odd_cell == phase_reg[0]) && in_set
                    && (store_reg[i] > store_reg[i + 1]))
                begin
                    store_next[i]     = store_reg[i + 1];
                    store_next[i + 1] = store_reg[i];
                end
            end
        end
        if (cmd.emit_step)
        begin
            for (int i = 0; i < MAX_ELEMENTS - 1; i++)
            begin
                store_next[i] = store_reg[i + 1];
            end
        end
    end

    // Counter and flag updates
    always_comb
    begin
        count_next    = count_reg;
        phase_next    = phase_reg;
        overflow_next = overflow_reg;
        if (cmd.load)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.sort_step)
        begin
            phase_next = status.phase_last ? '0 : phase_reg + PW'(1);
        end
        if (cmd.emit_step)
        begin
            count_next = count_reg - CW'(1);
            if (status.emit_last)
            begin
                overflow_next = 1'b0;
            end
        end
    end

    // Element row, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            store_reg[i] <= store_next[i];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            phase_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            overflow_reg <= overflow_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/odd_even_transposition_sorter.sv =====
// Top level of the odd-even transposition sorter.
`timescale 1ns / 1ps
`default_nettype none
// Collects a set of signed values, one per item, until an item marked last
// arrives; items beyond MAX_ELEMENTS are discarded and every result of that
// set carries dropped. A set of n stored values is loaded, then sorted in n
// phases (one odd or even compare-swap phase per cycle across all pairs of the
// element row at once), then emitted as n result items in ascending order, one
// per cycle when the sink is ready. Input is taken only while loading, and the
// last result carries end_of_set.
module odd_even_transposition_sorter #(
    parameter int MAX_ELEMENTS = oets_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire oets_pkg::in_item_t item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output oets_pkg::result_t       result
);

    oets_pkg::cmd_t    cmd;
    oets_pkg::status_t status;

    oets_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_last    (item.last),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .status       (status)
    );

    oets_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .status (status),
        .result (result)
    );

endmodule
`default_nettype wire
